FILE: rtl/ppa_pkg.sv
// Shared types and constants for the power phase angle block.
// Holds the quadrant codes, the arctangent table and the fixed-point formats.
// Depends on nothing; every other file refers to it by scoped names.
package ppa_pkg;

   // Guard bits appended below the magnitudes before rotation.
   localparam int GUARD = 24;
   // Number of entries in the arctangent table.
   localparam int TABLE_LEN = 24;
   // Angle accumulator width: centidegrees with 16 fraction bits, signed.
   localparam int Z_W = 32;
   localparam int Z_FRAC = 16;
   // Width of the truncated base angle (0 to 9000).
   localparam int BASE_W = 14;
   localparam int ANGLE_W = 16;
   localparam int CFG_W = 24;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CFG_W-1:0] MIN_ACTIVE_POWER_RESET = CFG_W'(5);
   localparam logic [ANGLE_W-1:0] HALF_TURN = ANGLE_W'(18000);
   localparam logic [ANGLE_W-1:0] FULL_TURN = ANGLE_W'(36000);
   localparam logic [BASE_W-1:0] RIGHT_ANGLE = BASE_W'(9000);
   localparam logic signed [Z_W-1:0] RIGHT_Q16 = Z_W'(9000 * 65536);

   // atan(2^-i) in centidegrees, Q16, rounded to nearest.
   localparam logic signed [Z_W-1:0] ATAN_Q16 [TABLE_LEN] = '{
      32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
      32'sd23437865,  32'sd11730358,  32'sd5866610,  32'sd2933484,
      32'sd1466764,   32'sd733385,    32'sd366693,   32'sd183346,
      32'sd91673,     32'sd45837,     32'sd22918,    32'sd11459,
      32'sd5730,      32'sd2865,      32'sd1432,     32'sd716,
      32'sd358,       32'sd179,       32'sd90,       32'sd45
   };

   typedef enum logic [1:0] {
      QUAD_FIRST,
      QUAD_SECOND,
      QUAD_THIRD,
      QUAD_FOURTH
   } quadrant_type;

   // Classification made by the front part and carried alongside the data.
   typedef struct packed {
      quadrant_type quadrant;
      logic         low_power;
   } class_type;

endpackage

FILE: rtl/power_phase_angle.sv
// Top level of the power phase angle block.
// Instantiates the front, queue and back parts and holds the threshold register.
// Depends on ppa_pkg, ppa_front, ppa_queue and ppa_back.

// The block turns a pair of active and reactive power readings, each given as
// a direction flag and an unsigned magnitude, into the phase angle in steps of
// 0.01 degree (0 to 36000) together with the quadrant minus one. A request is
// taken on any clock edge where start is high and busy is low, and one result
// appears on the rsp_ ports for exactly one cycle with rsp_valid high, in
// request order, after the front register, the queue and the back pipeline.
// A new request may be issued on every cycle: the rotator is a pipeline with
// one stage per rotation step, so the sustained rate is one request per clock,
// and busy stays low in normal use because the result side never stalls.
// When the active magnitude is at or below min_active_power the base angle is
// zero, so the result is 0, 18000 or 36000 depending on the quadrant; note that
// a zero base angle in the fourth quadrant gives 36000 rather than 0.
// min_active_power resets to 5 and is written through the csr_ port, which is
// always ready; it should only be changed while no request is in flight.
module power_phase_angle #(
   parameter int MAG_WIDTH    = 24,
   parameter int CORDIC_STEPS = 18
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel.
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_active_negative,
   input  logic                          req_reactive_negative,
   input  logic [MAG_WIDTH-1:0]          req_reactive_magnitude,
   input  logic [MAG_WIDTH-1:0]          req_active_magnitude,
   // Result channel.
   output logic                          rsp_valid,
   output logic [ppa_pkg::ANGLE_W-1:0]   rsp_angle_centidegrees,
   output logic [1:0]                    rsp_quadrant_index,
   // Threshold register write channel.
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ppa_pkg::CFG_W-1:0]     csr_min_active_power
);

   logic [ppa_pkg::CFG_W-1:0]  min_active_power_ff;

   logic                       push;
   logic                       queue_full;
   ppa_pkg::class_type         push_class;
   logic [MAG_WIDTH-1:0]       push_p, push_q;

   logic                       head_valid;
   ppa_pkg::class_type         head_class;
   logic [MAG_WIDTH-1:0]       head_p, head_q;

   // The register accepts a write in any cycle.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_active_power_ff <= ppa_pkg::MIN_ACTIVE_POWER_RESET;
      end else if (csr_valid && csr_ready) begin
         min_active_power_ff <= csr_min_active_power;
      end
   end

   // The front classifies each request and holds it until the queue has room.
   ppa_front #(
      .MAG_WIDTH(MAG_WIDTH)
   ) u_front (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_active_negative    (req_active_negative),
      .req_reactive_negative  (req_reactive_negative),
      .req_reactive_magnitude (req_reactive_magnitude),
      .req_active_magnitude   (req_active_magnitude),
      .min_active_power       (min_active_power_ff),
      .push                   (push),
      .queue_full             (queue_full),
      .push_class             (push_class),
      .push_p                 (push_p),
      .push_q                 (push_q)
   );

   ppa_queue #(
      .MAG_WIDTH(MAG_WIDTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_class (push_class),
      .push_p     (push_p),
      .push_q     (push_q),
      .full       (queue_full),
      .pop        (1'b1),
      .head_valid (head_valid),
      .head_class (head_class),
      .head_p     (head_p),
      .head_q     (head_q)
   );

   // The back pipeline never stalls, so it drains the queue head every cycle.
   ppa_back #(
      .MAG_WIDTH    (MAG_WIDTH),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (head_valid),
      .in_class     (head_class),
      .in_p         (head_p),
      .in_q         (head_q),
      .out_valid    (rsp_valid),
      .out_angle    (rsp_angle_centidegrees),
      .out_quadrant (rsp_quadrant_index)
   );

endmodule

FILE: rtl/ppa_front.sv
// Front part of the power phase angle block: takes requests and classifies them.
// Finds the quadrant and the low active power flag and holds the request
// until the queue takes it. Depends on ppa_pkg.
module ppa_front #(
   parameter int MAG_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_active_negative,
   input  logic                          req_reactive_negative,
   input  logic [MAG_WIDTH-1:0]          req_reactive_magnitude,
   input  logic [MAG_WIDTH-1:0]          req_active_magnitude,
   input  logic [ppa_pkg::CFG_W-1:0]     min_active_power,
   output logic                          push,
   input  logic                          queue_full,
   output ppa_pkg::class_type            push_class,
   output logic [MAG_WIDTH-1:0]          push_p,
   output logic [MAG_WIDTH-1:0]          push_q
);

   localparam int CMP_W = (MAG_WIDTH > ppa_pkg::CFG_W) ? MAG_WIDTH : ppa_pkg::CFG_W;

   logic                   valid_ff, valid_in;
   ppa_pkg::class_type     class_ff, class_in;
   logic [MAG_WIDTH-1:0]   p_ff, q_ff;
   logic                   accept;

   assign busy   = valid_ff && queue_full;
   assign accept = start && !busy;
   assign push   = valid_ff && !queue_full;

   always_comb begin
      if (!req_active_negative) begin
         class_in.quadrant = req_reactive_negative ? ppa_pkg::QUAD_FOURTH
                                                   : ppa_pkg::QUAD_FIRST;
      end else begin
         class_in.quadrant = req_reactive_negative ? ppa_pkg::QUAD_THIRD
                                                   : ppa_pkg::QUAD_SECOND;
      end
      class_in.low_power = (CMP_W'(req_active_magnitude) <= CMP_W'(min_active_power));
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         class_ff <= class_in;
         p_ff     <= req_active_magnitude;
         q_ff     <= req_reactive_magnitude;
      end
   end

   assign push_class = class_ff;
   assign push_p     = p_ff;
   assign push_q     = q_ff;

endmodule

FILE: rtl/ppa_queue.sv
// Short queue between the front and back parts of the power phase angle block.
// A small register file with read and write pointers. Depends on ppa_pkg.
module ppa_queue #(
   parameter int MAG_WIDTH = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ppa_pkg::class_type    push_class,
   input  logic [MAG_WIDTH-1:0]  push_p,
   input  logic [MAG_WIDTH-1:0]  push_q,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output ppa_pkg::class_type    head_class,
   output logic [MAG_WIDTH-1:0]  head_p,
   output logic [MAG_WIDTH-1:0]  head_q
);

   localparam int DEPTH = ppa_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ppa_pkg::class_type    class_mem [DEPTH];
   logic [MAG_WIDTH-1:0]  p_mem [DEPTH];
   logic [MAG_WIDTH-1:0]  q_mem [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]      count_ff;
   logic                  do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign do_pop     = pop && head_valid;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      if (ptr == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return ptr + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         class_mem[wr_ptr_ff] <= push_class;
         p_mem[wr_ptr_ff]     <= push_p;
         q_mem[wr_ptr_ff]     <= push_q;
      end
   end

   assign head_class = class_mem[rd_ptr_ff];
   assign head_p     = p_mem[rd_ptr_ff];
   assign head_q     = q_mem[rd_ptr_ff];

endmodule

FILE: rtl/ppa_back.sv
// Back part of the power phase angle block: a pipelined vectoring rotator.
// One rotation step per stage, then clamping, truncation and the quadrant
// mapping into the registered result. Depends on ppa_pkg.
module ppa_back #(
   parameter int MAG_WIDTH    = 24,
   parameter int CORDIC_STEPS = 18
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  ppa_pkg::class_type            in_class,
   input  logic [MAG_WIDTH-1:0]          in_p,
   input  logic [MAG_WIDTH-1:0]          in_q,
   output logic                          out_valid,
   output logic [ppa_pkg::ANGLE_W-1:0]   out_angle,
   output logic [1:0]                    out_quadrant
);

   localparam int STEPS = (CORDIC_STEPS > ppa_pkg::TABLE_LEN) ? ppa_pkg::TABLE_LEN
                                                              : CORDIC_STEPS;
   // Three spare top bits cover the sign and the growth of the vector, which
   // reaches about 2.3 times the larger magnitude when both are at full scale.
   localparam int XY_W = MAG_WIDTH + ppa_pkg::GUARD + 3;

   logic signed [XY_W-1:0]          x_ff [STEPS+1];
   logic signed [XY_W-1:0]          y_ff [STEPS+1];
   logic signed [ppa_pkg::Z_W-1:0]  z_ff [STEPS+1];
   ppa_pkg::class_type              class_ff [STEPS+1];
   logic [STEPS:0]                  valid_ff;

   logic                            out_valid_ff;
   logic [ppa_pkg::ANGLE_W-1:0]     angle_ff, angle_in;
   logic [1:0]                      quadrant_ff;
   logic [ppa_pkg::BASE_W-1:0]      base;
   logic signed [ppa_pkg::Z_W-1:0]  z_last;

   // Stage zero loads the guarded magnitudes.
   always_ff @(posedge clock) begin
      x_ff[0]     <= {3'b000, in_p, {ppa_pkg::GUARD{1'b0}}};
      y_ff[0]     <= {3'b000, in_q, {ppa_pkg::GUARD{1'b0}}};
      z_ff[0]     <= '0;
      class_ff[0] <= in_class;
   end

   genvar i;
   generate
      for (i = 0; i < STEPS; i++) begin : g_step
         logic signed [XY_W-1:0] dx, dy;
         logic                   y_pos;

         assign dx    = y_ff[i] >>> i;
         assign dy    = x_ff[i] >>> i;
         assign y_pos = !y_ff[i][XY_W-1] && (y_ff[i] != '0);

         always_ff @(posedge clock) begin
            if (y_pos) begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + ppa_pkg::ATAN_Q16[i];
            end else begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - ppa_pkg::ATAN_Q16[i];
            end
            class_ff[i+1] <= class_ff[i];
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[STEPS-1:0], in_valid};
      end
   end

   assign z_last = z_ff[STEPS];

   always_comb begin
      if (class_ff[STEPS].low_power || z_last[ppa_pkg::Z_W-1]) begin
         base = '0;
      end else if (z_last > ppa_pkg::RIGHT_Q16) begin
         base = ppa_pkg::RIGHT_ANGLE;
      end else begin
         base = z_last[ppa_pkg::Z_FRAC +: ppa_pkg::BASE_W];
      end
   end

   always_comb begin
      unique case (class_ff[STEPS].quadrant)
         ppa_pkg::QUAD_FIRST:  angle_in = ppa_pkg::ANGLE_W'(base);
         ppa_pkg::QUAD_SECOND: angle_in = ppa_pkg::HALF_TURN - ppa_pkg::ANGLE_W'(base);
         ppa_pkg::QUAD_THIRD:  angle_in = ppa_pkg::HALF_TURN + ppa_pkg::ANGLE_W'(base);
         default:              angle_in = ppa_pkg::FULL_TURN - ppa_pkg::ANGLE_W'(base);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      angle_ff    <= angle_in;
      quadrant_ff <= class_ff[STEPS].quadrant;
   end

   assign out_valid    = out_valid_ff;
   assign out_angle    = angle_ff;
   assign out_quadrant = quadrant_ff;

endmodule
